// ===== rtl/pdap_pkg.sv =====
// pdap_pkg: widths, opcodes, limits and the sideband type of the plane depth pipeline
// used by pdap_divider and plane_depth_at_point; no dependencies
package pdap_pkg;

  localparam int unsigned COORD_W = 32;
  localparam int unsigned DIFF_W  = COORD_W + 1;        // coordinate differences
  localparam int unsigned PROD_W  = 2 * DIFF_W;         // difference products
  localparam int unsigned NRM_W   = PROD_W + 1;         // normal components
  localparam int unsigned SPLIT_W = 34;                 // low slice of a normal component
  localparam int unsigned HI_W    = NRM_W - SPLIT_W;    // high slice, signed
  localparam int unsigned PLO_W   = SPLIT_W + 1 + DIFF_W;
  localparam int unsigned PHI_W   = HI_W + DIFF_W;
  localparam int unsigned NUM_W   = 101;                // dividend magnitude
  localparam int unsigned DEN_W   = NRM_W;              // divisor magnitude
  localparam int unsigned QUOT_W  = NUM_W + 1;          // signed quotient
  localparam int unsigned SUM_W   = QUOT_W + 1;         // sums after the divider

  localparam int unsigned DIV_STAGES      = NUM_W;
  localparam int unsigned PRE_DIV_STAGES  = 6;
  localparam int unsigned POST_DIV_STAGES = 4;
  localparam int unsigned LATENCY = PRE_DIV_STAGES + DIV_STAGES + POST_DIV_STAGES;

  localparam logic OP_POLY = 1'b0;
  localparam logic OP_LINE = 1'b1;

  localparam logic [COORD_W-1:0] DEPTH_MAX = 32'h7FFF_FFFF;
  localparam logic [COORD_W-1:0] DEPTH_MIN = 32'h8000_0000;

  typedef struct packed {
    logic                      line;
    logic [COORD_W-1:0]        p0z;
    logic signed [DIFF_W-1:0]  dz;
    logic                      x_zero;
    logic                      y_zero;
    logic                      nz_zero;
    logic                      a_pos;
    logic                      neg0;
    logic                      neg1;
  } side_t;

endpackage

// ===== rtl/plane_depth_at_point.sv =====
// plane_depth_at_point: depth of a query point on a plane or a line segment
// pipeline from accept to the out_valid_o strobe: 6 arithmetic stages,
// 101 divider stages (one quotient bit each), 4 finishing stages
// throughput one item per clock; busy stays low, the receiver cannot stall
// reset (async, active low) clears only the stage valid bits
module plane_depth_at_point (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  logic                            opcode_i,
  input  logic [pdap_pkg::COORD_W-1:0]    p0_x_i,
  input  logic [pdap_pkg::COORD_W-1:0]    p0_y_i,
  input  logic [pdap_pkg::COORD_W-1:0]    p0_z_i,
  input  logic [pdap_pkg::COORD_W-1:0]    p1_x_i,
  input  logic [pdap_pkg::COORD_W-1:0]    p1_y_i,
  input  logic [pdap_pkg::COORD_W-1:0]    p1_z_i,
  input  logic [pdap_pkg::COORD_W-1:0]    p2_x_i,
  input  logic [pdap_pkg::COORD_W-1:0]    p2_y_i,
  input  logic [pdap_pkg::COORD_W-1:0]    p2_z_i,
  input  logic [pdap_pkg::COORD_W-1:0]    query_x_i,
  input  logic [pdap_pkg::COORD_W-1:0]    query_y_i,
  output logic                            out_valid_o,
  output logic [pdap_pkg::COORD_W-1:0]    depth_o,
  output logic                            saturated_o
);

  localparam int unsigned DW = pdap_pkg::DIFF_W;
  localparam int unsigned CW = pdap_pkg::COORD_W;

  // the pipeline never holds an item back
  assign busy = 1'b0;

  logic accept;
  assign accept = start && !busy;

  // ---------------------------------------------------------------------------
  // stage 1: coordinate differences, 33 bit signed
  // u = p0 - p1, v = p1 - p2, a = p0 - q
  // ---------------------------------------------------------------------------
  logic                     s1_vld_q;
  logic signed [DW-1:0]     s1_ux_q, s1_uy_q, s1_uz_q, s1_vx_q, s1_vy_q, s1_vz_q;
  logic signed [DW-1:0]     s1_ax_q, s1_ay_q;
  logic                     s1_line_q;
  logic [CW-1:0]            s1_p0z_q;

  always_ff @(posedge clk_i) begin
    s1_ux_q   <= {p0_x_i[CW-1], p0_x_i} - {p1_x_i[CW-1], p1_x_i};
    s1_uy_q   <= {p0_y_i[CW-1], p0_y_i} - {p1_y_i[CW-1], p1_y_i};
    s1_uz_q   <= {p0_z_i[CW-1], p0_z_i} - {p1_z_i[CW-1], p1_z_i};
    s1_vx_q   <= {p1_x_i[CW-1], p1_x_i} - {p2_x_i[CW-1], p2_x_i};
    s1_vy_q   <= {p1_y_i[CW-1], p1_y_i} - {p2_y_i[CW-1], p2_y_i};
    s1_vz_q   <= {p1_z_i[CW-1], p1_z_i} - {p2_z_i[CW-1], p2_z_i};
    s1_ax_q   <= {p0_x_i[CW-1], p0_x_i} - {query_x_i[CW-1], query_x_i};
    s1_ay_q   <= {p0_y_i[CW-1], p0_y_i} - {query_y_i[CW-1], query_y_i};
    s1_line_q <= (opcode_i == pdap_pkg::OP_LINE);
    s1_p0z_q  <= p0_z_i;
  end

  // ---------------------------------------------------------------------------
  // stage 2: cross product terms and the line numerators
  // line mode: dz*(q - p0) equals uz*a since both factors flip sign
  // ---------------------------------------------------------------------------
  logic                                  s2_vld_q;
  logic signed [pdap_pkg::PROD_W-1:0]    s2_m0_q, s2_m1_q, s2_m2_q, s2_m3_q;
  logic signed [pdap_pkg::PROD_W-1:0]    s2_m4_q, s2_m5_q, s2_m6_q, s2_m7_q;
  logic signed [DW-1:0]                  s2_ax_q, s2_ay_q, s2_ux_q, s2_uy_q, s2_uz_q;
  logic                                  s2_line_q;
  logic [CW-1:0]                         s2_p0z_q;

  always_ff @(posedge clk_i) begin
    s2_m0_q   <= s1_uy_q * s1_vz_q;
    s2_m1_q   <= s1_uz_q * s1_vy_q;
    s2_m2_q   <= s1_uz_q * s1_vx_q;
    s2_m3_q   <= s1_ux_q * s1_vz_q;
    s2_m4_q   <= s1_ux_q * s1_vy_q;
    s2_m5_q   <= s1_uy_q * s1_vx_q;
    s2_m6_q   <= s1_uz_q * s1_ax_q;
    s2_m7_q   <= s1_uz_q * s1_ay_q;
    s2_ax_q   <= s1_ax_q;
    s2_ay_q   <= s1_ay_q;
    s2_ux_q   <= s1_ux_q;
    s2_uy_q   <= s1_uy_q;
    s2_uz_q   <= s1_uz_q;
    s2_line_q <= s1_line_q;
    s2_p0z_q  <= s1_p0z_q;
  end

  // ---------------------------------------------------------------------------
  // stage 3: normal n = u x v, 67 bit signed
  // ---------------------------------------------------------------------------
  logic                                  s3_vld_q;
  logic signed [pdap_pkg::NRM_W-1:0]     s3_nx_q, s3_ny_q, s3_nz_q;
  logic signed [pdap_pkg::PROD_W-1:0]    s3_m6_q, s3_m7_q;
  logic signed [DW-1:0]                  s3_ax_q, s3_ay_q, s3_ux_q, s3_uy_q, s3_uz_q;
  logic                                  s3_line_q;
  logic [CW-1:0]                         s3_p0z_q;

  always_ff @(posedge clk_i) begin
    s3_nx_q   <= s2_m0_q - s2_m1_q;
    s3_ny_q   <= s2_m2_q - s2_m3_q;
    s3_nz_q   <= s2_m4_q - s2_m5_q;
    s3_m6_q   <= s2_m6_q;
    s3_m7_q   <= s2_m7_q;
    s3_ax_q   <= s2_ax_q;
    s3_ay_q   <= s2_ay_q;
    s3_ux_q   <= s2_ux_q;
    s3_uy_q   <= s2_uy_q;
    s3_uz_q   <= s2_uz_q;
    s3_line_q <= s2_line_q;
    s3_p0z_q  <= s2_p0z_q;
  end

  // ---------------------------------------------------------------------------
  // stage 4: nx*ax and ny*ay as partial products over a split normal
  // low slice unsigned, high slice signed
  // ---------------------------------------------------------------------------
  logic                                  s4_vld_q;
  logic signed [pdap_pkg::PLO_W-1:0]     s4_plx_q, s4_ply_q;
  logic signed [pdap_pkg::PHI_W-1:0]     s4_phx_q, s4_phy_q;
  logic signed [pdap_pkg::NRM_W-1:0]     s4_nz_q;
  logic signed [pdap_pkg::PROD_W-1:0]    s4_m6_q, s4_m7_q;
  logic signed [DW-1:0]                  s4_ux_q, s4_uy_q, s4_uz_q;
  logic                                  s4_line_q;
  logic [CW-1:0]                         s4_p0z_q;

  always_ff @(posedge clk_i) begin
    s4_plx_q  <= $signed({1'b0, s3_nx_q[pdap_pkg::SPLIT_W-1:0]}) * s3_ax_q;
    s4_ply_q  <= $signed({1'b0, s3_ny_q[pdap_pkg::SPLIT_W-1:0]}) * s3_ay_q;
    s4_phx_q  <= $signed(s3_nx_q[pdap_pkg::NRM_W-1:pdap_pkg::SPLIT_W]) * s3_ax_q;
    s4_phy_q  <= $signed(s3_ny_q[pdap_pkg::NRM_W-1:pdap_pkg::SPLIT_W]) * s3_ay_q;
    s4_nz_q   <= s3_nz_q;
    s4_m6_q   <= s3_m6_q;
    s4_m7_q   <= s3_m7_q;
    s4_ux_q   <= s3_ux_q;
    s4_uy_q   <= s3_uy_q;
    s4_uz_q   <= s3_uz_q;
    s4_line_q <= s3_line_q;
    s4_p0z_q  <= s3_p0z_q;
  end

  // ---------------------------------------------------------------------------
  // stage 5: plane numerator A = nx*(p0x - qx) + ny*(p0y - qy), 101 bit
  // ---------------------------------------------------------------------------
  logic                                  s5_vld_q;
  logic signed [pdap_pkg::NUM_W-1:0]     s5_a_q;
  logic signed [pdap_pkg::NRM_W-1:0]     s5_nz_q;
  logic signed [pdap_pkg::PROD_W-1:0]    s5_m6_q, s5_m7_q;
  logic signed [DW-1:0]                  s5_ux_q, s5_uy_q, s5_uz_q;
  logic                                  s5_line_q;
  logic [CW-1:0]                         s5_p0z_q;

  always_ff @(posedge clk_i) begin
    s5_a_q    <= $signed({s4_phx_q, {pdap_pkg::SPLIT_W{1'b0}}}) + s4_plx_q
               + $signed({s4_phy_q, {pdap_pkg::SPLIT_W{1'b0}}}) + s4_ply_q;
    s5_nz_q   <= s4_nz_q;
    s5_m6_q   <= s4_m6_q;
    s5_m7_q   <= s4_m7_q;
    s5_ux_q   <= s4_ux_q;
    s5_uy_q   <= s4_uy_q;
    s5_uz_q   <= s4_uz_q;
    s5_line_q <= s4_line_q;
    s5_p0z_q  <= s4_p0z_q;
  end

  // ---------------------------------------------------------------------------
  // stage 6: pick dividend and divisor per lane, split off signs
  // lane 0: polygon A / nz, or line x estimate; lane 1: line y estimate
  // ---------------------------------------------------------------------------
  logic signed [pdap_pkg::NUM_W-1:0]     n0, n1, n0_neg, n1_neg;
  logic signed [pdap_pkg::NRM_W-1:0]     d0, d1, d0_neg, d1_neg, dx_l, dy_l;
  logic signed [DW-1:0]                  dz_l;
  pdap_pkg::side_t                       side_d;

  always_comb begin
    dx_l   = '0 - {{(pdap_pkg::NRM_W-DW){s5_ux_q[DW-1]}}, s5_ux_q};
    dy_l   = '0 - {{(pdap_pkg::NRM_W-DW){s5_uy_q[DW-1]}}, s5_uy_q};
    dz_l   = '0 - s5_uz_q;
    n1     = {{(pdap_pkg::NUM_W-pdap_pkg::PROD_W){s5_m7_q[pdap_pkg::PROD_W-1]}}, s5_m7_q};
    d1     = dy_l;
    if (s5_line_q) begin
      n0 = {{(pdap_pkg::NUM_W-pdap_pkg::PROD_W){s5_m6_q[pdap_pkg::PROD_W-1]}}, s5_m6_q};
      d0 = dx_l;
    end else begin
      n0 = s5_a_q;
      d0 = s5_nz_q;
    end
    n0_neg = '0 - n0;
    n1_neg = '0 - n1;
    d0_neg = '0 - d0;
    d1_neg = '0 - d1;

    side_d.line    = s5_line_q;
    side_d.p0z     = s5_p0z_q;
    side_d.dz      = dz_l;
    side_d.x_zero  = (s5_ux_q == '0);
    side_d.y_zero  = (s5_uy_q == '0);
    side_d.nz_zero = (s5_nz_q == '0);
    side_d.a_pos   = !s5_a_q[pdap_pkg::NUM_W-1] && (s5_a_q != '0);
    side_d.neg0    = n0[pdap_pkg::NUM_W-1] ^ d0[pdap_pkg::NRM_W-1];
    side_d.neg1    = n1[pdap_pkg::NUM_W-1] ^ d1[pdap_pkg::NRM_W-1];
  end

  logic                                  s6_vld_q;
  logic [pdap_pkg::NUM_W-1:0]            s6_num0_q, s6_num1_q;
  logic [pdap_pkg::DEN_W-1:0]            s6_den0_q, s6_den1_q;
  pdap_pkg::side_t                       s6_side_q;

  always_ff @(posedge clk_i) begin
    s6_num0_q <= n0[pdap_pkg::NUM_W-1] ? n0_neg : n0;
    s6_num1_q <= n1[pdap_pkg::NUM_W-1] ? n1_neg : n1;
    s6_den0_q <= d0[pdap_pkg::NRM_W-1] ? d0_neg : d0;
    s6_den1_q <= d1[pdap_pkg::NRM_W-1] ? d1_neg : d1;
    s6_side_q <= side_d;
  end

  // ---------------------------------------------------------------------------
  // divider lanes; a zero divisor gives a don't-care quotient that the
  // finishing stages replace
  // ---------------------------------------------------------------------------
  logic                        div0_vld, div1_vld;
  logic [pdap_pkg::NUM_W-1:0]  quot0, quot1;

  pdap_divider u_div0 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s6_vld_q),
    .num_i   (s6_num0_q),
    .den_i   (s6_den0_q),
    .valid_o (div0_vld),
    .quot_o  (quot0)
  );

  pdap_divider u_div1 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s6_vld_q),
    .num_i   (s6_num1_q),
    .den_i   (s6_den1_q),
    .valid_o (div1_vld),
    .quot_o  (quot1)
  );

  // sideband delay line matching the divider depth
  pdap_pkg::side_t side_q [pdap_pkg::DIV_STAGES];

  always_ff @(posedge clk_i) begin
    side_q[0] <= s6_side_q;
    for (int i = 1; i < pdap_pkg::DIV_STAGES; i++) begin
      side_q[i] <= side_q[i-1];
    end
  end

  pdap_pkg::side_t side_out;
  assign side_out = side_q[pdap_pkg::DIV_STAGES-1];

  // ---------------------------------------------------------------------------
  // stage 7: signed quotients; a zero run in line mode gives min(0, dz)
  // ---------------------------------------------------------------------------
  logic signed [pdap_pkg::QUOT_W-1:0]    q0, q1, q0_neg, q1_neg, q0_s, q1_s, mz;

  always_comb begin
    q0     = {1'b0, quot0};
    q1     = {1'b0, quot1};
    q0_neg = '0 - q0;
    q1_neg = '0 - q1;
    q0_s   = side_out.neg0 ? q0_neg : q0;
    q1_s   = side_out.neg1 ? q1_neg : q1;
    if (side_out.dz[DW-1]) begin
      mz = {{(pdap_pkg::QUOT_W-DW){1'b1}}, side_out.dz};
    end else begin
      mz = '0;
    end
  end

  logic                                  s7_vld_q;
  logic signed [pdap_pkg::QUOT_W-1:0]    s7_v0_q, s7_v1_q;
  pdap_pkg::side_t                       s7_side_q;

  always_ff @(posedge clk_i) begin
    s7_v0_q   <= (side_out.line && side_out.x_zero) ? mz : q0_s;
    s7_v1_q   <= side_out.y_zero ? mz : q1_s;
    s7_side_q <= side_out;
  end

  // stage 8: sum of the two line estimates
  logic                                  s8_vld_q;
  logic signed [pdap_pkg::SUM_W-1:0]     s8_sum_q;
  logic signed [pdap_pkg::QUOT_W-1:0]    s8_v0_q;
  pdap_pkg::side_t                       s8_side_q;

  always_ff @(posedge clk_i) begin
    s8_sum_q  <= s7_v0_q + s7_v1_q;
    s8_v0_q   <= s7_v0_q;
    s8_side_q <= s7_side_q;
  end

  // stage 9: halve toward zero in line mode, the quotient as is in polygon mode
  logic signed [pdap_pkg::SUM_W-1:0]     rnd_sum;
  assign rnd_sum = s8_sum_q + {{(pdap_pkg::SUM_W-1){1'b0}}, s8_sum_q[pdap_pkg::SUM_W-1]};

  logic                                  s9_vld_q;
  logic signed [pdap_pkg::QUOT_W-1:0]    s9_val_q;
  pdap_pkg::side_t                       s9_side_q;

  always_ff @(posedge clk_i) begin
    s9_val_q  <= s8_side_q.line ? rnd_sum[pdap_pkg::SUM_W-1:1] : s8_v0_q;
    s9_side_q <= s8_side_q;
  end

  // stage 10: add p0z and clamp; an edge-on plane goes to a rail by the sign of A
  logic signed [pdap_pkg::SUM_W-1:0]     res;
  logic                                  fits;
  logic [CW-1:0]                         depth_d;
  logic                                  sat_d;

  always_comb begin
    // signed sum so the quotient keeps its sign extension
    res  = $signed({{(pdap_pkg::SUM_W-CW){s9_side_q.p0z[CW-1]}}, s9_side_q.p0z}) + s9_val_q;
    fits = (&res[pdap_pkg::SUM_W-1:CW-1]) || !(|res[pdap_pkg::SUM_W-1:CW-1]);
    if (!s9_side_q.line && s9_side_q.nz_zero) begin
      depth_d = s9_side_q.a_pos ? pdap_pkg::DEPTH_MAX : pdap_pkg::DEPTH_MIN;
      sat_d   = 1'b1;
    end else if (fits) begin
      depth_d = res[CW-1:0];
      sat_d   = 1'b0;
    end else begin
      depth_d = res[pdap_pkg::SUM_W-1] ? pdap_pkg::DEPTH_MIN : pdap_pkg::DEPTH_MAX;
      sat_d   = 1'b1;
    end
  end

  logic             out_vld_q;
  logic [CW-1:0]    depth_q;
  logic             sat_q;

  always_ff @(posedge clk_i) begin
    depth_q <= depth_d;
    sat_q   <= sat_d;
  end

  // valid bits of every stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      s3_vld_q  <= 1'b0;
      s4_vld_q  <= 1'b0;
      s5_vld_q  <= 1'b0;
      s6_vld_q  <= 1'b0;
      s7_vld_q  <= 1'b0;
      s8_vld_q  <= 1'b0;
      s9_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      s1_vld_q  <= accept;
      s2_vld_q  <= s1_vld_q;
      s3_vld_q  <= s2_vld_q;
      s4_vld_q  <= s3_vld_q;
      s5_vld_q  <= s4_vld_q;
      s6_vld_q  <= s5_vld_q;
      s7_vld_q  <= div0_vld;
      s8_vld_q  <= s7_vld_q;
      s9_vld_q  <= s8_vld_q;
      out_vld_q <= s9_vld_q;
    end
  end

  assign out_valid_o = out_vld_q;
  assign depth_o     = depth_q;
  assign saturated_o = sat_q;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  a_item_arrives: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##(pdap_pkg::LATENCY) out_valid_o)
    else $error("accepted item did not arrive at the output");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $past(accept, pdap_pkg::LATENCY))
    else $error("result strobe without an accepted item");

  a_lanes_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div0_vld == div1_vld)
    else $error("divider lanes out of step");

endmodule

// ===== rtl/pdap_divider.sv =====
// pdap_divider: pipelined unsigned restoring divider, one quotient bit per stage
// depends on pdap_pkg for widths and stage count
module pdap_divider (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  input  logic [pdap_pkg::NUM_W-1:0]   num_i,
  input  logic [pdap_pkg::DEN_W-1:0]   den_i,
  output logic                         valid_o,
  output logic [pdap_pkg::NUM_W-1:0]   quot_o
);

  logic                         vld_q [pdap_pkg::DIV_STAGES];
  logic [pdap_pkg::NUM_W-1:0]   num_q [pdap_pkg::DIV_STAGES];
  logic [pdap_pkg::DEN_W-1:0]   rem_q [pdap_pkg::DIV_STAGES];
  logic [pdap_pkg::DEN_W-1:0]   den_q [pdap_pkg::DIV_STAGES];

  for (genvar i = 0; i < pdap_pkg::DIV_STAGES; i++) begin : g_stage
    logic                         vld_p;
    logic [pdap_pkg::NUM_W-1:0]   num_p;
    logic [pdap_pkg::DEN_W-1:0]   rem_p;
    logic [pdap_pkg::DEN_W-1:0]   den_p;
    logic [pdap_pkg::DEN_W:0]     trial;
    logic [pdap_pkg::DEN_W:0]     diff;
    logic                         ge;

    if (i == 0) begin : g_first
      assign vld_p = valid_i;
      assign num_p = num_i;
      assign rem_p = '0;
      assign den_p = den_i;
    end else begin : g_next
      assign vld_p = vld_q[i-1];
      assign num_p = num_q[i-1];
      assign rem_p = rem_q[i-1];
      assign den_p = den_q[i-1];
    end

    // shift in the next dividend bit and try the subtract
    assign trial = {rem_p, num_p[pdap_pkg::NUM_W-1]};
    assign diff  = trial - {1'b0, den_p};
    assign ge    = trial >= {1'b0, den_p};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else begin
        vld_q[i] <= vld_p;
      end
    end

    always_ff @(posedge clk_i) begin
      num_q[i] <= {num_p[pdap_pkg::NUM_W-2:0], ge};
      rem_q[i] <= ge ? diff[pdap_pkg::DEN_W-1:0] : trial[pdap_pkg::DEN_W-1:0];
      den_q[i] <= den_p;
    end
  end

  assign valid_o = vld_q[pdap_pkg::DIV_STAGES-1];
  assign quot_o  = num_q[pdap_pkg::DIV_STAGES-1];

endmodule

// ===== bench/pdap_checker.sv =====
// pdap_checker: watches the item and result channels of plane_depth_at_point,
// predicts each depth and compares it; depends on pdap_pkg
module pdap_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  input  logic                         busy,
  input  logic                         opcode_i,
  input  logic [pdap_pkg::COORD_W-1:0] p0_x_i,
  input  logic [pdap_pkg::COORD_W-1:0] p0_y_i,
  input  logic [pdap_pkg::COORD_W-1:0] p0_z_i,
  input  logic [pdap_pkg::COORD_W-1:0] p1_x_i,
  input  logic [pdap_pkg::COORD_W-1:0] p1_y_i,
  input  logic [pdap_pkg::COORD_W-1:0] p1_z_i,
  input  logic [pdap_pkg::COORD_W-1:0] p2_x_i,
  input  logic [pdap_pkg::COORD_W-1:0] p2_y_i,
  input  logic [pdap_pkg::COORD_W-1:0] p2_z_i,
  input  logic [pdap_pkg::COORD_W-1:0] query_x_i,
  input  logic [pdap_pkg::COORD_W-1:0] query_y_i,
  input  logic                         out_valid_o,
  input  logic [pdap_pkg::COORD_W-1:0] depth_o,
  input  logic                         saturated_o,
  output int                           mismatches_o,
  output int                           pending_o,
  output int                           checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [159:0] wide_t;

  typedef struct packed {
    logic [pdap_pkg::COORD_W-1:0] depth;
    logic                         sat;
  } depth_t;

  depth_t depth_q[$];

  function automatic depth_t clamp_depth(wide_t v);
    depth_t r;
    if (v > wide_t'(64'sh7FFF_FFFF)) begin
      r.depth = pdap_pkg::DEPTH_MAX;
      r.sat   = 1'b1;
    end else if (v < -wide_t'(64'sh8000_0000)) begin
      r.depth = pdap_pkg::DEPTH_MIN;
      r.sat   = 1'b1;
    end else begin
      r.depth = v[pdap_pkg::COORD_W-1:0];
      r.sat   = 1'b0;
    end
    return r;
  endfunction

  function automatic depth_t predict_depth(logic op,
      logic signed [31:0] ax, logic signed [31:0] ay, logic signed [31:0] az,
      logic signed [31:0] bx, logic signed [31:0] by, logic signed [31:0] bz,
      logic signed [31:0] cx, logic signed [31:0] cy, logic signed [31:0] cz,
      logic signed [31:0] qx, logic signed [31:0] qy);
    wide_t ux, uy, uz, vx, vy, vz, nx, ny, nz, num, xe, ye, z0;
    depth_t r;
    z0 = az;
    if (op == pdap_pkg::OP_LINE) begin
      ux = wide_t'(bx) - ax;
      uy = wide_t'(by) - ay;
      uz = wide_t'(bz) - az;
      // a flat run in x or y contributes min(0, dz)
      xe = (ux == 0) ? ((uz < 0) ? uz : 0) : (uz * (wide_t'(qx) - ax)) / ux;
      ye = (uy == 0) ? ((uz < 0) ? uz : 0) : (uz * (wide_t'(qy) - ay)) / uy;
      r = clamp_depth(z0 + (xe + ye) / 2);
    end else begin
      ux = wide_t'(ax) - bx;  uy = wide_t'(ay) - by;  uz = wide_t'(az) - bz;
      vx = wide_t'(bx) - cx;  vy = wide_t'(by) - cy;  vz = wide_t'(bz) - cz;
      nx = uy * vz - uz * vy;
      ny = uz * vx - ux * vz;
      nz = ux * vy - uy * vx;
      num = nx * (wide_t'(ax) - qx) + ny * (wide_t'(ay) - qy);
      if (nz == 0) begin
        r.depth = (num > 0) ? pdap_pkg::DEPTH_MAX : pdap_pkg::DEPTH_MIN;
        r.sat   = 1'b1;
      end else begin
        r = clamp_depth(z0 + num / nz);
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h expected %h (result %0d)", what, got, want, checked_o);
    mismatches_o++;
  endtask

  initial begin
    mismatches_o = 0;
    checked_o    = 0;
    pending_o    = 0;
  end

  always @(posedge clk_i) begin
    depth_t want;
    if (rst_ni && start && !busy)
      depth_q.push_back(predict_depth(opcode_i, p0_x_i, p0_y_i, p0_z_i, p1_x_i, p1_y_i,
                                      p1_z_i, p2_x_i, p2_y_i, p2_z_i, query_x_i,
                                      query_y_i));
    if (rst_ni && out_valid_o) begin
      if (depth_q.size() == 0) begin
        report_mismatch("unexpected result", depth_o, '0);
      end else begin
        want = depth_q.pop_front();
        if (depth_o !== want.depth) report_mismatch("depth", depth_o, want.depth);
        if (saturated_o !== want.sat) report_mismatch("saturated", saturated_o, want.sat);
      end
      checked_o++;
    end
    pending_o = depth_q.size();
  end
endmodule

// ===== bench/tb_top.sv =====
// tb_top: stimulus and verdict for plane_depth_at_point
// depends on pdap_pkg, the block and pdap_checker
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 900;
  localparam int CYCLE_LIMIT  = 200000;

  logic clk_i, rst_ni, start, busy, opcode_i, out_valid_o, saturated_o;
  logic [pdap_pkg::COORD_W-1:0] p0_x_i, p0_y_i, p0_z_i, p1_x_i, p1_y_i, p1_z_i;
  logic [pdap_pkg::COORD_W-1:0] p2_x_i, p2_y_i, p2_z_i, query_x_i, query_y_i, depth_o;
  int mismatches, pending, checked, cycles;
  int idle_pct;
  int n_poly, n_line;

  plane_depth_at_point dut (.*);

  pdap_checker chk (
    .clk_i, .rst_ni, .start, .busy, .opcode_i, .p0_x_i, .p0_y_i, .p0_z_i,
    .p1_x_i, .p1_y_i, .p1_z_i, .p2_x_i, .p2_y_i, .p2_z_i, .query_x_i, .query_y_i,
    .out_valid_o, .depth_o, .saturated_o,
    .mismatches_o(mismatches), .pending_o(pending), .checked_o(checked)
  );

  always begin
    clk_i = 1'b1; #10;
    clk_i = 1'b0; #10;
  end

  // watchdog on a cycle count
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Some tests failed");
      $finish;
    end
  end

  // one item: optional random gap, then hold start until the block takes it;
  // called at a rising edge and returns at the rising edge of acceptance
  task automatic send_item(logic op, logic [31:0] ax, logic [31:0] ay, logic [31:0] az,
                           logic [31:0] bx, logic [31:0] by, logic [31:0] bz,
                           logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
                           logic [31:0] qx, logic [31:0] qy);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk_i);
    end
    start <= 1'b1;
    opcode_i <= op;
    p0_x_i <= ax;  p0_y_i <= ay;  p0_z_i <= az;
    p1_x_i <= bx;  p1_y_i <= by;  p1_z_i <= bz;
    p2_x_i <= cx;  p2_y_i <= cy;  p2_z_i <= cz;
    query_x_i <= qx;  query_y_i <= qy;
    if (op == pdap_pkg::OP_LINE) n_line++; else n_poly++;
    // busy is checked mid-cycle so the edge that follows is the accepting one
    forever begin
      @(negedge clk_i);
      if (!busy) break;
    end
    @(posedge clk_i);
  endtask

  // coordinate: mostly modest values so depths land in range, some full width
  function automatic logic [31:0] rand_coord(int mode);
    case (mode)
      0: return $urandom();
      1: return 32'($signed($urandom_range(2 * 65536 * 64)) - 65536 * 64);
      default: return 32'($signed($urandom_range(2048)) - 1024);
    endcase
  endfunction

  task automatic send_random();
    int mode;
    logic [31:0] ax, ay, cz;
    mode = $urandom_range(9) < 2 ? 0 : ($urandom_range(2) == 0 ? 2 : 1);
    ax = rand_coord(mode);
    ay = rand_coord(mode);
    cz = rand_coord(mode);
    case ($urandom_range(9))
      // flat run: p1 shares an axis with p0
      0: send_item(pdap_pkg::OP_LINE, ax, ay, rand_coord(mode), ax, rand_coord(mode), cz,
                   $urandom(), $urandom(), $urandom(), rand_coord(mode), rand_coord(mode));
      // edge-on plane: all three vertices share one y coordinate
      1: send_item(pdap_pkg::OP_POLY, ax, ay, rand_coord(mode), rand_coord(mode), ay, cz,
                   rand_coord(mode), ay, rand_coord(mode), rand_coord(mode),
                   rand_coord(mode));
      2, 3, 4: send_item(pdap_pkg::OP_LINE, ax, ay, rand_coord(mode), rand_coord(mode),
                         rand_coord(mode), cz, $urandom(), $urandom(), $urandom(),
                         rand_coord(mode), rand_coord(mode));
      default: send_item(pdap_pkg::OP_POLY, ax, ay, rand_coord(mode), rand_coord(mode),
                         rand_coord(mode), cz, rand_coord(mode), rand_coord(mode),
                         rand_coord(mode), rand_coord(mode), rand_coord(mode));
    endcase
  endtask

  localparam logic [31:0] ONE  = 32'h0001_0000;
  localparam logic [31:0] MONE = 32'hFFFF_0000;
  localparam logic [31:0] PMAX = 32'h7FFF_FFFF;
  localparam logic [31:0] PMIN = 32'h8000_0000;

  initial begin
    cycles = 0;
    n_poly = 0;
    n_line = 0;
    idle_pct = 28;
    rst_ni = 1'b0;
    start <= 1'b0;
    opcode_i <= pdap_pkg::OP_POLY;
    {p0_x_i, p0_y_i, p0_z_i, p1_x_i, p1_y_i, p1_z_i} <= '0;
    {p2_x_i, p2_y_i, p2_z_i, query_x_i, query_y_i} <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: plain plane and line
    send_item(pdap_pkg::OP_POLY, 0, 0, ONE, ONE, 0, 2 * ONE, 0, ONE, 3 * ONE,
              ONE / 2, ONE / 2);
    send_item(pdap_pkg::OP_LINE, 0, 0, 0, 4 * ONE, 2 * ONE, ONE, 32'hDEAD_BEEF,
              32'h1234_5678, 32'hFFFF_FFFF, ONE, ONE);
    // edge-on plane with positive, negative and zero numerator
    send_item(pdap_pkg::OP_POLY, 0, 0, 0, MONE, 0, MONE, 32'hFFFE_0000, 0,
              32'hFFFD_0000, 0, 5);
    send_item(pdap_pkg::OP_POLY, 0, 0, 0, MONE, 0, MONE, 32'hFFFE_0000, 0,
              32'hFFFD_0000, 0, -5);
    send_item(pdap_pkg::OP_POLY, 0, 0, 0, MONE, 0, MONE, 32'hFFFE_0000, 0,
              32'hFFFD_0000, 7, 0);
    send_item(pdap_pkg::OP_POLY, 5, 5, 5, 5, 5, 5, 5, 5, 5, 0, 0);
    // flat runs in x, in y and in both, with dz of either sign
    send_item(pdap_pkg::OP_LINE, ONE, 0, 0, ONE, 3 * ONE, -3 * ONE, 0, 0, 0, 2 * ONE, ONE);
    send_item(pdap_pkg::OP_LINE, 0, ONE, 0, 3 * ONE, ONE, 3 * ONE, 0, 0, 0, 2 * ONE, ONE);
    send_item(pdap_pkg::OP_LINE, ONE, ONE, 10, ONE, ONE, -7, 0, 0, 0, 0, 0);
    send_item(pdap_pkg::OP_LINE, ONE, ONE, 10, ONE, ONE, 7, 0, 0, 0, 0, 0);
    // extremes of the fields and clamping either way
    send_item(pdap_pkg::OP_POLY, PMIN, PMIN, PMIN, PMAX, PMIN, PMAX, PMIN, PMAX, PMIN,
              PMAX, PMAX);
    send_item(pdap_pkg::OP_POLY, PMAX, PMAX, PMAX, PMIN, PMAX, PMIN, PMAX, PMIN, PMAX,
              PMIN, PMIN);
    send_item(pdap_pkg::OP_LINE, PMIN, PMIN, PMIN, PMAX, PMAX, PMAX, PMAX, PMAX, PMAX,
              PMAX, PMAX);
    send_item(pdap_pkg::OP_LINE, PMAX, PMAX, PMAX, PMIN, PMIN, PMIN, PMIN, PMIN, PMIN,
              PMIN, PMIN);
    send_item(pdap_pkg::OP_LINE, 0, 0, PMAX, 1, 1, PMIN, 0, 0, 0, PMAX, PMAX);
    send_item(pdap_pkg::OP_LINE, 0, 0, PMIN, 1, 1, PMAX, 0, 0, 0, PMAX, PMAX);
    send_item(pdap_pkg::OP_POLY, 0, 0, PMAX, 1, 0, PMAX, 0, 1, PMIN, PMAX, PMAX);
    send_item(pdap_pkg::OP_POLY, '1, '1, '1, 0, 0, 0, '1, 0, '1, '1, '1);

    // hold off until the directed results are all back
    start <= 1'b0;
    wait (pending == 0);
    @(posedge clk_i);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS / 3) idle_pct = 78;
      if (i == 2 * RANDOM_ITEMS / 3) idle_pct = 0;
      send_random();
    end
    start <= 1'b0;

    wait (pending == 0);
    repeat (pdap_pkg::LATENCY + 20) @(posedge clk_i);

    $display("covered %0d plane and %0d line items, %0d results checked",
             n_poly, n_line, checked);
    $display("directed extremes, edge-on planes, flat runs, clamping; random mix");
    if (mismatches == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
